[hdl/fde_pkg.sv]
package fde_pkg;

  localparam int ENTRY_BYTES = 32;
  localparam int POS_W       = $clog2(ENTRY_BYTES);
  localparam int NAME_BYTES  = 11;
  localparam int FIFO_DEPTH  = 4;

  localparam logic [POS_W-1:0] POS_FIRST     = POS_W'(0);
  localparam logic [POS_W-1:0] POS_SECOND    = POS_W'(1);
  localparam logic [POS_W-1:0] POS_ATTR      = POS_W'(11);
  localparam logic [POS_W-1:0] POS_CLUS_HI0  = POS_W'(20);
  localparam logic [POS_W-1:0] POS_CLUS_HI1  = POS_W'(21);
  localparam logic [POS_W-1:0] POS_CLUS_LO0  = POS_W'(26);
  localparam logic [POS_W-1:0] POS_CLUS_LO1  = POS_W'(27);
  localparam logic [POS_W-1:0] POS_SIZE      = POS_W'(28);
  localparam logic [POS_W-1:0] POS_LAST      = POS_W'(ENTRY_BYTES - 1);

  localparam logic [7:0] BYTE_END_MARK = 8'h00;
  localparam logic [7:0] BYTE_DELETED  = 8'hE5;
  localparam logic [7:0] BYTE_DOT      = 8'h2E;
  localparam logic [7:0] BYTE_SPACE    = 8'h20;

  localparam logic [7:0] ATTR_LONG_NAME  = 8'h0F;
  localparam logic [7:0] ATTR_HIDDEN_SYS = 8'h06;
  localparam logic [7:0] ATTR_VOLUME     = 8'h08;
  localparam logic [7:0] ATTR_DIRECTORY  = 8'h10;
  localparam logic [7:0] ATTR_ARCHIVE    = 8'h20;

  localparam logic [31:0] CLUSTER_BIAS = 32'd2;

  // Configuration register indexes.
  localparam logic CFG_CLUSTER_BEGIN = 1'b0;
  localparam logic CFG_CLUSTER_SIZE  = 1'b1;

  localparam logic [31:0] RESET_CLUSTER_BEGIN = 32'd0;
  localparam logic [7:0]  RESET_SPC           = 8'd1;

  typedef enum logic [1:0] {
    KIND_VOLUME    = 2'd0,
    KIND_DIRECTORY = 2'd1,
    KIND_FILE      = 2'd2,
    KIND_OTHER     = 2'd3
  } fde_kind_t;

  // One classified directory record, handed from the front to the back.
  typedef struct packed {
    logic        end_of_dir;
    fde_kind_t   entry_kind;
    logic [7:0]  attributes;
    logic [63:0] name_head;
    logic [23:0] name_tail;
    logic [31:0] first_cluster;
    logic [31:0] size_bytes;
  } fde_rec_t;

endpackage

[hdl/fde_front.sv]
module fde_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        data_byte,
  input  logic              dir_start,
  input  logic              fifo_full,
  output logic              push,
  output fde_pkg::fde_rec_t rec
);

  logic [fde_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic                      ended_r, ended_nxt;
  logic [7:0]                name_r [fde_pkg::NAME_BYTES];
  logic [7:0]                attr_r;
  logic [31:0]               clus_r;
  logic [23:0]               size_r;
  logic [1:0]                dot_r, dot_nxt;

  logic                      accept;
  logic                      ended_eff;
  logic [fde_pkg::POS_W-1:0] pos_eff;
  logic                      capture;
  logic                      end_mark;
  logic                      dropped;
  logic                      emit;
  fde_pkg::fde_kind_t        kind;
  logic [63:0]               head;

  assign in_ready  = !fifo_full;
  assign accept    = in_valid && in_ready;
  assign ended_eff = ended_r && !dir_start;
  assign pos_eff   = dir_start ? fde_pkg::POS_FIRST : pos_r;
  assign end_mark  = accept && !ended_eff && (pos_eff == fde_pkg::POS_FIRST) &&
                     (data_byte == fde_pkg::BYTE_END_MARK);
  assign capture   = accept && !ended_eff && !end_mark;

  // Everything checked here is final by the last byte of the entry.
  assign dropped = (name_r[0] == fde_pkg::BYTE_DELETED) ||
                   (attr_r == fde_pkg::ATTR_LONG_NAME) ||
                   ((attr_r & fde_pkg::ATTR_HIDDEN_SYS) != 8'h00) ||
                   (((attr_r & fde_pkg::ATTR_DIRECTORY) != 8'h00) && (dot_r == 2'b01));
  assign emit = capture && (pos_eff == fde_pkg::POS_LAST) && !dropped;
  assign push = end_mark || emit;

  always_comb begin
    if ((attr_r & fde_pkg::ATTR_VOLUME) != 8'h00) begin
      kind = fde_pkg::KIND_VOLUME;
    end else if ((attr_r & fde_pkg::ATTR_DIRECTORY) != 8'h00) begin
      kind = fde_pkg::KIND_DIRECTORY;
    end else if ((attr_r & fde_pkg::ATTR_ARCHIVE) != 8'h00) begin
      kind = fde_pkg::KIND_FILE;
    end else begin
      kind = fde_pkg::KIND_OTHER;
    end
  end

  assign head = {name_r[0], name_r[1], name_r[2], name_r[3],
                 name_r[4], name_r[5], name_r[6], name_r[7]};

  always_comb begin
    rec = '0;
    if (end_mark) begin
      rec.end_of_dir = 1'b1;
    end else begin
      rec.entry_kind    = kind;
      rec.attributes    = attr_r;
      rec.name_head     = head;
      rec.name_tail     = {name_r[8], name_r[9], name_r[10]};
      rec.first_cluster = clus_r;
      rec.size_bytes    = {data_byte, size_r};
    end
  end

  // Name flags: bit 0 tracks a dot or dot-dot name, bit 1 a non-space in bytes two to ten.
  always_comb begin
    dot_nxt = dot_r;
    if (capture) begin
      if (pos_eff == fde_pkg::POS_FIRST) begin
        dot_nxt = {1'b0, data_byte == fde_pkg::BYTE_DOT};
      end else if (pos_eff == fde_pkg::POS_SECOND) begin
        if (dot_r[0] && (data_byte != fde_pkg::BYTE_DOT) &&
            (data_byte != fde_pkg::BYTE_SPACE)) begin
          dot_nxt = {dot_r[1], 1'b0};
        end
      end else if (pos_eff < fde_pkg::POS_W'(fde_pkg::NAME_BYTES)) begin
        if (data_byte != fde_pkg::BYTE_SPACE) begin
          dot_nxt = {1'b1, dot_r[0]};
        end
      end
    end
  end

  always_comb begin
    pos_nxt   = pos_r;
    ended_nxt = ended_r;
    if (accept) begin
      if (dir_start) begin
        pos_nxt   = fde_pkg::POS_FIRST;
        ended_nxt = 1'b0;
      end
      if (end_mark) begin
        pos_nxt   = fde_pkg::POS_FIRST;
        ended_nxt = 1'b1;
      end else if (capture) begin
        pos_nxt = pos_eff + fde_pkg::POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= fde_pkg::POS_FIRST;
      ended_r <= 1'b0;
      dot_r   <= 2'b00;
    end else begin
      pos_r   <= pos_nxt;
      ended_r <= ended_nxt;
      dot_r   <= dot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      for (int i = 0; i < fde_pkg::NAME_BYTES; i++) begin
        if (pos_eff == fde_pkg::POS_W'(i)) begin
          name_r[i] <= data_byte;
        end
      end
      if (pos_eff == fde_pkg::POS_ATTR) begin
        attr_r <= data_byte;
      end
      if (pos_eff == fde_pkg::POS_CLUS_HI0) begin
        clus_r[23:16] <= data_byte;
      end
      if (pos_eff == fde_pkg::POS_CLUS_HI1) begin
        clus_r[31:24] <= data_byte;
      end
      if (pos_eff == fde_pkg::POS_CLUS_LO0) begin
        clus_r[7:0] <= data_byte;
      end
      if (pos_eff == fde_pkg::POS_CLUS_LO1) begin
        clus_r[15:8] <= data_byte;
      end
      if (pos_eff >= fde_pkg::POS_SIZE) begin
        case (pos_eff[1:0])
          2'd0:    size_r[7:0]   <= data_byte;
          2'd1:    size_r[15:8]  <= data_byte;
          2'd2:    size_r[23:16] <= data_byte;
          default: ;
        endcase
      end
    end
  end

`ifndef SYNTH
  a_ended_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ended_r |-> (pos_r == fde_pkg::POS_FIRST))
    else $error("end flag set with a partial entry position");

  a_end_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (push && rec.end_of_dir) |=> ended_r)
    else $error("end record pushed without setting the end flag");

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !fifo_full)
    else $error("record pushed into a full queue");
`endif

endmodule

[hdl/fde_fifo.sv]
module fde_fifo #(
  parameter int DEPTH = fde_pkg::FIFO_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  fde_pkg::fde_rec_t wr_rec,
  output logic              full,
  input  logic              pop,
  output logic              rd_valid,
  output fde_pkg::fde_rec_t rd_rec
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fde_pkg::fde_rec_t mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_rec   = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_rec;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue fill count beyond depth");
`endif

endmodule

[hdl/fde_back.sv]
module fde_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [31:0]       cluster_begin_sector,
  input  logic [7:0]        cluster_sectors,
  input  logic              rec_valid,
  input  fde_pkg::fde_rec_t rec,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output fde_pkg::fde_rec_t out_rec,
  output logic [31:0]       out_sector
);

  logic              s1_valid_r, s1_valid_nxt;
  fde_pkg::fde_rec_t s1_rec_r;
  logic [31:0]       s1_prod_r;
  logic              out_valid_r, out_valid_nxt;
  fde_pkg::fde_rec_t out_rec_r;
  logic [31:0]       out_sector_r;

  logic              s1_ready, s2_ready;
  logic [31:0]       clus_adj;
  logic [39:0]       prod_full;
  logic              s1_load, s2_load;

  assign s2_ready = !out_valid_r || out_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign pop      = rec_valid && s1_ready;
  assign s1_load  = pop;
  assign s2_load  = s1_valid_r && s2_ready;

  // Stage one: cluster offset times cluster size, kept modulo 2^32.
  assign clus_adj  = rec.first_cluster - fde_pkg::CLUSTER_BIAS;
  assign prod_full = clus_adj * cluster_sectors;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_ready) begin
      s1_valid_nxt = rec_valid;
    end
    out_valid_nxt = out_valid_r;
    if (s2_ready) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_rec_r  <= rec;
      s1_prod_r <= prod_full[31:0];
    end
    if (s2_load) begin
      out_rec_r    <= s1_rec_r;
      out_sector_r <= s1_rec_r.end_of_dir ? 32'd0 : cluster_begin_sector + s1_prod_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_rec    = out_rec_r;
  assign out_sector = out_sector_r;

`ifndef SYNTH
  a_end_is_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rec_r.end_of_dir) |-> (out_sector_r == 32'd0))
    else $error("end-of-directory result carries a sector address");
`endif

endmodule

[hdl/fat32_directory_entry_filter_top.sv]
// FAT32 directory entry filter. Directory bytes arrive one per beat on the in_ side and are
// counted into 32-byte entries; a beat with in_tuser set starts a new directory and is byte
// zero of an entry. An entry that begins with a zero byte produces one end-of-directory beat
// (out_tlast high, every other field zero) at once, and later bytes are ignored until the
// next directory start. Deleted, long-name, hidden, system, dot and dot-dot entries produce
// nothing; every other entry produces one beat when its last byte is taken, carrying its
// kind, attribute byte, name, start cluster, size and the sector where the start cluster
// begins. The block takes one byte every cycle as long as its four-record queue has room;
// the front end forms a record from the byte being taken and its registered entry state and
// writes it into the queue at the very edge that takes the byte; the result beat then passes
// through a register stage that forms the cluster-times-size product and an output register
// that adds the cluster base.
// Configuration (cfg_index 0: sector of cluster two, 1: sectors per cluster) may only be
// written while no beat is in flight.
module fat32_directory_entry_filter_top #(
  parameter int FIFO_DEPTH = fde_pkg::FIFO_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  // Input stream.
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tuser,   // [0] dir_start
  // Result stream.
  output logic         out_tvalid,
  input  logic         out_tready,
  // [1:0] entry_kind, [9:2] attributes, [73:10] name_head, [97:74] name_tail,
  // [129:98] first_cluster, [161:130] size_bytes, [193:162] first_sector, rest zero
  output logic [199:0] out_tdata,
  output logic         out_tlast,  // end_of_dir
  // Configuration write port.
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_wdata
);

  logic [31:0]       cluster_begin_r, cluster_begin_nxt;
  logic [7:0]        spc_r, spc_nxt;

  logic              push;
  fde_pkg::fde_rec_t push_rec;
  logic              fifo_full;
  logic              pop;
  logic              head_valid;
  fde_pkg::fde_rec_t head_rec;
  fde_pkg::fde_rec_t res_rec;
  logic [31:0]       res_sector;

  // Configuration registers.
  always_comb begin
    cluster_begin_nxt = cluster_begin_r;
    spc_nxt           = spc_r;
    if (cfg_we) begin
      unique case (cfg_index)
        fde_pkg::CFG_CLUSTER_BEGIN: cluster_begin_nxt = cfg_wdata;
        fde_pkg::CFG_CLUSTER_SIZE:  spc_nxt           = cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cluster_begin_r <= fde_pkg::RESET_CLUSTER_BEGIN;
      spc_r           <= fde_pkg::RESET_SPC;
    end else begin
      cluster_begin_r <= cluster_begin_nxt;
      spc_r           <= spc_nxt;
    end
  end

  // Front end: byte counting, field capture and entry filtering.
  fde_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .data_byte (in_tdata),
    .dir_start (in_tuser),
    .fifo_full (fifo_full),
    .push      (push),
    .rec       (push_rec)
  );

  // The queue lets the byte side run on while results wait at the output.
  fde_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_rec   (push_rec),
    .full     (fifo_full),
    .pop      (pop),
    .rd_valid (head_valid),
    .rd_rec   (head_rec)
  );

  // Back end: first sector arithmetic and the output register.
  fde_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cluster_begin_sector (cluster_begin_r),
    .cluster_sectors      (spc_r),
    .rec_valid            (head_valid),
    .rec                  (head_rec),
    .pop                  (pop),
    .out_valid            (out_tvalid),
    .out_ready            (out_tready),
    .out_rec              (res_rec),
    .out_sector           (res_sector)
  );

  assign out_tlast = res_rec.end_of_dir;
  assign out_tdata = {6'd0,
                      res_sector,
                      res_rec.size_bytes,
                      res_rec.first_cluster,
                      res_rec.name_tail,
                      res_rec.name_head,
                      res_rec.attributes,
                      res_rec.entry_kind};

endmodule
